// ===== hdl/mks_pkg.sv =====
`default_nettype none

package mks_pkg;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_SCAN,
        PH_COMBO,
        PH_RELEASE
    } t_phase;

    localparam logic [1:0] REG_COMBO_COLUMNS   = 2'd0;
    localparam logic [1:0] REG_COMBO_WINDOW    = 2'd1;
    localparam logic [1:0] REG_RELEASE_QUIET   = 2'd2;

    localparam logic [7:0] COMBO_COLUMNS_RESET = 8'h81;
    localparam logic [7:0] COMBO_WINDOW_RESET  = 8'd10;
    localparam logic [7:0] RELEASE_QUIET_RESET = 8'd10;

    typedef struct packed {
        logic [7:0] combo_columns;
        logic [7:0] combo_window_samples;
        logic [7:0] release_quiet_samples;
    } t_cfg;

    typedef struct packed {
        logic [3:0] row_drive;
        logic       key_valid;
        logic [4:0] key_index;
        logic       combo_fired;
        logic       busy_res;
    } t_result;

endpackage

`default_nettype wire

// ===== hdl/mks_scan_core.sv =====
`default_nettype none

module mks_scan_core
    import mks_pkg::*;
#(
    parameter int ROW_COUNT    = 4,
    parameter int COLUMN_COUNT = 8
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_step,
    input  wire t_cfg       i_cfg,
    input  wire logic       i_scan_request,
    input  wire logic [7:0] i_column_levels,
    output t_result         o_result
);

    localparam int              RowW    = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
    localparam logic [RowW-1:0] LastRow = RowW'(ROW_COUNT - 1);
    localparam logic [7:0]      ColMask = 8'((1 << COLUMN_COUNT) - 1);
    localparam logic [7:0]      RowMask = 8'((1 << ROW_COUNT) - 1);

    function automatic logic [2:0] lowest_column(input logic [7:0] p);
        logic [2:0] c;
        c = 3'd0;
        for (int i = COLUMN_COUNT - 1; i >= 0; i--) begin
            if (p[i]) begin
                c = 3'(i);
            end
        end
        return c;
    endfunction

    function automatic logic [3:0] drive_for_row(input logic [RowW-1:0] row);
        logic [7:0] d;
        d = (RowMask ^ (8'd1 << row)) & RowMask;
        return d[3:0];
    endfunction

    function automatic logic [7:0] at_least_one(input logic [7:0] v);
        return (v == 8'd0) ? 8'd1 : v;
    endfunction

    t_phase          r_phase, n_phase;
    logic [RowW-1:0] r_row, n_row;
    logic [7:0]      r_count, n_count;
    logic            r_combo_seen, n_combo_seen;

    logic [7:0]      w_pressed;
    logic            w_any;
    logic            w_last;
    logic            w_combo_hit;
    logic [RowW-1:0] w_row_inc;
    logic [7:0]      w_count_inc;
    logic            w_match;
    logic            w_seen_new;
    logic            w_window_end;
    logic [7:0]      w_quiet_count;
    logic            w_quiet_end;
    logic [4:0]      w_key_index;

    assign w_pressed     = ~i_column_levels & ColMask;
    assign w_any         = |w_pressed;
    assign w_last        = (r_row == LastRow);
    assign w_combo_hit   = w_last && |(w_pressed & i_cfg.combo_columns);
    assign w_row_inc     = r_row + RowW'(1);
    assign w_count_inc   = r_count + 8'd1;
    assign w_match       = (w_pressed == i_cfg.combo_columns) && !r_combo_seen;
    assign w_seen_new    = r_combo_seen | w_match;
    assign w_window_end  = (w_count_inc >= at_least_one(i_cfg.combo_window_samples));
    assign w_quiet_count = w_any ? 8'd0 : w_count_inc;
    assign w_quiet_end   = (w_quiet_count >= at_least_one(i_cfg.release_quiet_samples));
    assign w_key_index   = 5'({r_row, 3'b000}) | 5'(lowest_column(w_pressed));

    always_comb begin
        n_phase      = r_phase;
        n_row        = r_row;
        n_count      = r_count;
        n_combo_seen = r_combo_seen;
        case (r_phase)
            PH_IDLE: begin
                if (i_scan_request) begin
                    n_phase = PH_SCAN;
                    n_row   = '0;
                end
            end
            PH_SCAN: begin
                if (w_combo_hit) begin
                    n_phase      = PH_COMBO;
                    n_count      = 8'd0;
                    n_combo_seen = 1'b0;
                end else if (w_any || w_last) begin
                    n_phase = PH_RELEASE;
                    n_count = 8'd0;
                end else begin
                    n_row = w_row_inc;
                end
            end
            PH_COMBO: begin
                n_combo_seen = w_seen_new;
                if (w_window_end) begin
                    n_phase = PH_RELEASE;
                    n_count = 8'd0;
                end else begin
                    n_count = w_count_inc;
                end
            end
            PH_RELEASE: begin
                if (w_quiet_end) begin
                    n_phase = PH_IDLE;
                    n_count = 8'd0;
                end else begin
                    n_count = w_quiet_count;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    always_comb begin
        o_result = '0;
        case (r_phase)
            PH_IDLE: begin
                if (i_scan_request) begin
                    o_result.row_drive = drive_for_row('0);
                end
            end
            PH_SCAN: begin
                if (w_combo_hit) begin
                    o_result.row_drive = drive_for_row(r_row);
                end else if (w_any) begin
                    o_result.key_valid = 1'b1;
                    o_result.key_index = w_key_index;
                end else if (!w_last) begin
                    o_result.row_drive = drive_for_row(w_row_inc);
                end
            end
            PH_COMBO: begin
                o_result.combo_fired = w_match;
                if (w_window_end) begin
                    if (!w_seen_new && w_any) begin
                        o_result.key_valid = 1'b1;
                        o_result.key_index = w_key_index;
                    end
                end else begin
                    o_result.row_drive = drive_for_row(r_row);
                end
            end
            default: begin
                o_result = '0;
            end
        endcase
        o_result.busy_res = (n_phase != PH_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_row        <= '0;
            r_count      <= 8'd0;
            r_combo_seen <= 1'b0;
        end else if (i_step) begin
            r_phase      <= n_phase;
            r_row        <= n_row;
            r_count      <= n_count;
            r_combo_seen <= n_combo_seen;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/matrix_keypad_scanner.sv =====
// Key matrix scanner, one column poll sample per request.
//
// Input channel (i_in_valid / o_in_ready): each request carries a scan
// request flag and the raw active-low column levels. Output channel
// (o_out_valid / i_out_ready): exactly one result per request, in order,
// with the row levels for the next sample, a key report, a combo flag and
// the busy flag.
// An accepted request waits in the input register; the state update then
// writes its result into the result register.
// Throughput: one request per cycle unless the receiver stalls; the scan
// state update is a single pass of priority encoder, compare and counter
// logic. The input register takes a new request while a finished result
// waits; when the receiver stalls, the result and the pending request
// both hold and o_in_ready drops once both stages are full.
// Reset (synchronous, active low): scanner idle, no result pending,
// registers back to combo pattern 0x81, window 10, quiet count 10.
// Registers live on the APB port at byte addresses 0, 4 and 8; write them
// only while the scanner is idle with no result outstanding.
`default_nettype none

module matrix_keypad_scanner
    import mks_pkg::*;
#(
    parameter int ROW_COUNT    = 4,
    parameter int COLUMN_COUNT = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_scan_request,
    input  wire logic [7:0]  i_column_levels,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic      [3:0]  o_row_drive,
    output logic             o_key_valid,
    output logic      [4:0]  o_key_index,
    output logic             o_combo_fired,
    output logic             o_busy_res
);

    t_cfg       r_cfg;
    logic       r_in_valid, n_in_valid;
    logic       r_in_req;
    logic [7:0] r_in_cols;
    logic       r_out_valid, n_out_valid;
    t_result    r_result;
    t_result    w_result;
    logic       w_step;
    logic       w_cfg_write;

    assign pready      = 1'b1;
    assign w_cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.combo_columns         <= COMBO_COLUMNS_RESET;
            r_cfg.combo_window_samples  <= COMBO_WINDOW_RESET;
            r_cfg.release_quiet_samples <= RELEASE_QUIET_RESET;
        end else if (w_cfg_write) begin
            case (paddr[3:2])
                REG_COMBO_COLUMNS: r_cfg.combo_columns         <= pwdata[7:0];
                REG_COMBO_WINDOW:  r_cfg.combo_window_samples  <= pwdata[7:0];
                REG_RELEASE_QUIET: r_cfg.release_quiet_samples <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_COMBO_COLUMNS: prdata = {24'd0, r_cfg.combo_columns};
            REG_COMBO_WINDOW:  prdata = {24'd0, r_cfg.combo_window_samples};
            REG_RELEASE_QUIET: prdata = {24'd0, r_cfg.release_quiet_samples};
            default:           prdata = 32'd0;
        endcase
    end

    assign w_step     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_step;

    always_comb begin
        n_in_valid  = o_in_ready ? i_in_valid : r_in_valid;
        n_out_valid = w_step ? 1'b1 : (r_out_valid && !i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_req  <= i_scan_request;
            r_in_cols <= i_column_levels;
        end
        if (w_step) begin
            r_result <= w_result;
        end
    end

    mks_scan_core #(
        .ROW_COUNT    (ROW_COUNT),
        .COLUMN_COUNT (COLUMN_COUNT)
    ) u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (w_step),
        .i_cfg           (r_cfg),
        .i_scan_request  (r_in_req),
        .i_column_levels (r_in_cols),
        .o_result        (w_result)
    );

    assign o_out_valid   = r_out_valid;
    assign o_row_drive   = r_result.row_drive;
    assign o_key_valid   = r_result.key_valid;
    assign o_key_index   = r_result.key_index;
    assign o_combo_fired = r_result.combo_fired;
    assign o_busy_res    = r_result.busy_res;

endmodule

`default_nettype wire

// ===== hdl/mks_checker.sv =====
`default_nettype none

module mks_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_out_valid,
    input wire logic       i_out_ready,
    input wire logic [3:0] o_row_drive,
    input wire logic       o_key_valid,
    input wire logic [4:0] o_key_index,
    input wire logic       o_combo_fired,
    input wire logic       o_busy_res
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_row_drive)
            && $stable(o_key_valid) && $stable(o_key_index)
            && $stable(o_combo_fired) && $stable(o_busy_res))
        else $error("result changed while stalled");

    a_key_then_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_key_valid |-> o_busy_res)
        else $error("key reported without release wait");

    a_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_key_valid |-> o_key_index == 5'd0)
        else $error("key index set without key report");

    a_combo_suppress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_combo_fired |-> !o_key_valid)
        else $error("combo and key reported together");

    a_idle_rows_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_busy_res |-> o_row_drive == 4'd0)
        else $error("rows not all low while idle");

endmodule

bind matrix_keypad_scanner mks_checker u_mks_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_row_drive   (o_row_drive),
    .o_key_valid   (o_key_valid),
    .o_key_index   (o_key_index),
    .o_combo_fired (o_combo_fired),
    .o_busy_res    (o_busy_res)
);

`default_nettype wire
